// ----- hdl/bpc_pkg.sv -----
package bpc_pkg;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned MS_W    = 16;
	localparam int unsigned LIMIT_W = 3;
	localparam int unsigned COUNT_W = 4;
	localparam int unsigned ADDR_W  = 5;
	localparam int unsigned DATA_W  = 32;

	// register index, taken from paddr[4:2]
	typedef enum logic [2:0] {
		REG_IDLE_LEVEL   = 3'd0,
		REG_BOUNCE_MS    = 3'd1,
		REG_DOUBLE_MS    = 3'd2,
		REG_LONG_MS      = 3'd3,
		REG_PRESS_LIMIT  = 3'd4,
		REG_RSVD5        = 3'd5,
		REG_RSVD6        = 3'd6,
		REG_RSVD7        = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_PRESS   = 2'd1,
		EV_RELEASE = 2'd2,
		EV_LONG    = 2'd3
	} ev_t;

	typedef struct packed {
		logic               idle_level;
		logic [MS_W-1:0]    bounce_ms;
		logic [MS_W-1:0]    double_press_ms;
		logic [MS_W-1:0]    long_press_ms;
		logic [LIMIT_W-1:0] press_limit;
	} cfg_t;

	localparam logic               RST_IDLE_LEVEL  = 1'b1;
	localparam logic [MS_W-1:0]    RST_BOUNCE_MS   = 16'd50;
	localparam logic [MS_W-1:0]    RST_DOUBLE_MS   = 16'd300;
	localparam logic [MS_W-1:0]    RST_LONG_MS     = 16'd1000;
	localparam logic [LIMIT_W-1:0] RST_PRESS_LIMIT = 3'd3;

endpackage

// ----- hdl/button_press_classifier_top.sv -----
// button press classifier
//
// s_* channel: one request per pin sample, tdata carries the raw level and
// a wrapping millisecond timestamp. m_* channel: exactly one result per
// sample, tuser carries the event kind (none, press, release, long hold) and
// tdata the press number of a press event.
// the apb port holds idle level, bounce time, multi-press window, long-hold
// time and press limit; write it only while no sample is in flight.
// a sample is taken into the input register, classified from there and
// registered in the result register, which drives m_*.
// throughput: one sample per cycle while m_tready is high; the debounce/count
// state is updated in the same cycle the sample leaves the input register, so
// only a low m_tready limits the rate below one per clock.
// stall: when m_tready is low the result register holds and the input
// register holds one more sample; s_tready drops only when both are full.
// reset: arst_n clears the registers to their default values, the edge
// time to zero, the button to not pressed and the press count to zero.
module button_press_classifier_top (
	input  logic        clk,
	input  logic        arst_n,
	// apb configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// sample input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // [0] pin_level, [32:1] now_ms, [39:33] zero
	// classified output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [3:0] press_count, [7:4] zero
	output logic [1:0]  m_tuser   // [1:0] event_res
);

	bpc_pkg::cfg_t cfg;

	// input register
	logic                          valid_s1;
	logic                          pin_level_s1;
	logic [bpc_pkg::TIME_W-1:0]    now_ms_s1;
	logic                          advance;

	// result register
	logic                          valid_s2;
	bpc_pkg::ev_t                  event_s2;
	logic [bpc_pkg::COUNT_W-1:0]   count_s2;

	bpc_pkg::ev_t                  event_c;
	logic [bpc_pkg::COUNT_W-1:0]   count_c;

	bpc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// a sample moves on when the result register is empty or being drained
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			pin_level_s1 <= s_tdata[0];
			now_ms_s1    <= s_tdata[32:1];
		end
	end

	// state update happens exactly once per sample, on advance
	bpc_classify u_classify (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (advance),
		.pin_level   (pin_level_s1),
		.now_ms      (now_ms_s1),
		.cfg         (cfg),
		.event_res   (event_c),
		.press_count (count_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_s2 <= event_c;
			count_s2 <= count_c;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'd0, count_s2};
	assign m_tuser  = event_s2;

endmodule

// ----- hdl/bpc_cfg_regs.sv -----
module bpc_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bpc_pkg::ADDR_W-1:0]  paddr,
	input  logic [bpc_pkg::DATA_W-1:0]  pwdata,
	output logic [bpc_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output bpc_pkg::cfg_t               cfg
);

	bpc_pkg::cfg_t    cfg_q;
	bpc_pkg::reg_idx_t idx;
	logic             wr_en;

	assign pready = 1'b1;
	assign idx    = bpc_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_level      <= bpc_pkg::RST_IDLE_LEVEL;
			cfg_q.bounce_ms       <= bpc_pkg::RST_BOUNCE_MS;
			cfg_q.double_press_ms <= bpc_pkg::RST_DOUBLE_MS;
			cfg_q.long_press_ms   <= bpc_pkg::RST_LONG_MS;
			cfg_q.press_limit     <= bpc_pkg::RST_PRESS_LIMIT;
		end else if (wr_en) begin
			unique case (idx)
				bpc_pkg::REG_IDLE_LEVEL:  cfg_q.idle_level      <= pwdata[0];
				bpc_pkg::REG_BOUNCE_MS:   cfg_q.bounce_ms       <= pwdata[15:0];
				bpc_pkg::REG_DOUBLE_MS:   cfg_q.double_press_ms <= pwdata[15:0];
				bpc_pkg::REG_LONG_MS:     cfg_q.long_press_ms   <= pwdata[15:0];
				bpc_pkg::REG_PRESS_LIMIT: cfg_q.press_limit     <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			bpc_pkg::REG_IDLE_LEVEL:  prdata[0]    = cfg_q.idle_level;
			bpc_pkg::REG_BOUNCE_MS:   prdata[15:0] = cfg_q.bounce_ms;
			bpc_pkg::REG_DOUBLE_MS:   prdata[15:0] = cfg_q.double_press_ms;
			bpc_pkg::REG_LONG_MS:     prdata[15:0] = cfg_q.long_press_ms;
			bpc_pkg::REG_PRESS_LIMIT: prdata[2:0]  = cfg_q.press_limit;
			default:                  prdata       = '0;
		endcase
	end

endmodule

// ----- hdl/bpc_classify.sv -----
module bpc_classify (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          pin_level,
	input  logic [bpc_pkg::TIME_W-1:0]    now_ms,
	input  bpc_pkg::cfg_t                 cfg,
	output bpc_pkg::ev_t                  event_res,
	output logic [bpc_pkg::COUNT_W-1:0]   press_count
);

	logic [bpc_pkg::TIME_W-1:0]  last_edge_q;
	logic                        last_pressed_q;
	logic                        long_flag_q;
	logic [bpc_pkg::COUNT_W-1:0] cnt_q;

	logic [bpc_pkg::TIME_W-1:0]  last_edge_d;
	logic                        last_pressed_d;
	logic                        long_flag_d;
	logic [bpc_pkg::COUNT_W-1:0] cnt_d;

	logic                        pressed;
	logic [bpc_pkg::TIME_W-1:0]  elapsed;
	logic                        edge_ok;
	logic                        in_window;
	logic                        quiet;
	logic                        multi_en;
	logic [bpc_pkg::COUNT_W-1:0] limit_ext;
	logic [bpc_pkg::COUNT_W-1:0] limit_p1;
	logic [bpc_pkg::COUNT_W-1:0] adv_cnt;
	logic [bpc_pkg::COUNT_W-1:0] press_cnt;

	assign pressed   = pin_level != cfg.idle_level;
	assign elapsed   = now_ms - last_edge_q;
	assign edge_ok   = (pressed != last_pressed_q) &&
	                   (elapsed > {16'd0, cfg.bounce_ms});
	assign in_window = elapsed < {16'd0, cfg.double_press_ms};
	// quiet once elapsed exceeds the multi-press window plus one ms
	assign quiet     = elapsed > ({16'd0, cfg.double_press_ms} + 32'd1);
	assign multi_en  = cfg.press_limit > 3'd1;
	assign limit_ext = {1'b0, cfg.press_limit};
	assign limit_p1  = limit_ext + 4'd1;

	// saturate at limit + 1, also pulls down a count left over from a higher limit
	assign adv_cnt   = !multi_en ? 4'd1 :
	                   (cnt_q <= limit_ext) ? cnt_q + 4'd1 : limit_p1;
	assign press_cnt = ((cnt_q == 4'd0) || in_window) ? adv_cnt : cnt_q;

	always_comb begin
		last_edge_d    = last_edge_q;
		last_pressed_d = last_pressed_q;
		long_flag_d    = long_flag_q;
		cnt_d          = cnt_q;
		event_res      = bpc_pkg::EV_NONE;
		press_count    = '0;
		if (edge_ok) begin
			if (pressed) begin
				cnt_d = press_cnt;
				if (press_cnt <= limit_ext) begin
					event_res   = bpc_pkg::EV_PRESS;
					press_count = press_cnt;
				end
			end else begin
				long_flag_d = 1'b0;
				event_res   = bpc_pkg::EV_RELEASE;
			end
			last_edge_d    = now_ms;
			last_pressed_d = pressed;
		end else if (pressed && !long_flag_q &&
		             (elapsed > {16'd0, cfg.long_press_ms})) begin
			long_flag_d = 1'b1;
			cnt_d       = '0;
			event_res   = bpc_pkg::EV_LONG;
		end else if (!pressed && (quiet || !multi_en)) begin
			cnt_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_edge_q    <= '0;
			last_pressed_q <= 1'b0;
			long_flag_q    <= 1'b0;
			cnt_q          <= '0;
		end else if (en) begin
			last_edge_q    <= last_edge_d;
			last_pressed_q <= last_pressed_d;
			long_flag_q    <= long_flag_d;
			cnt_q          <= cnt_d;
		end
	end

endmodule
